[rtl/plip_pkg.sv]
// ----------------------------------------------------------------------------
// plip_pkg
// Shared types, character codes and digit decode for the integer literal
// parser with radix prefix.
// ----------------------------------------------------------------------------
`default_nettype none

package plip_pkg;

    // width of the value field on the result channel
    localparam int unsigned VALUE_W = 32;

    // radix codes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;
    localparam logic [1:0] RADIX_OCT = 2'd3;

    // character position codes
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_UPPER_B = 8'h42;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;

    // one input transaction
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       empty_literal;
    } t_item;

    // decoded digit: bad set for any non-digit character
    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } t_digit;

    // map a character to its digit value, base independent
    function automatic t_digit char_digit(input logic [7:0] ch);
        t_digit d;
        d.bad = 1'b1;
        d.val = 4'd0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            d.bad = 1'b0;
            d.val = 4'(ch - CHAR_ZERO);
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
            d.bad = 1'b0;
            d.val = 4'(ch - CHAR_UPPER_A + 8'd10);
        end
        return d;
    endfunction

    // digit value too large for the radix
    function automatic logic digit_out_of_range(input logic [1:0] radix,
                                                input logic [3:0] val);
        logic r;
        r = 1'b0;
        unique case (radix)
            RADIX_DEC: r = (val > 4'd9);
            RADIX_HEX: r = 1'b0;
            RADIX_BIN: r = (val > 4'd1);
            RADIX_OCT: r = (val > 4'd7);
            default:   r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/plip_ifs.sv]
// ----------------------------------------------------------------------------
// plip channel interfaces
// Valid/ready channels for character transactions in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface plip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;
    logic       empty_literal;

    modport source (output valid, output character, output last_char,
                    output empty_literal, input ready);
    modport sink   (input valid, input character, input last_char,
                    input empty_literal, output ready);
endinterface

interface plip_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

`default_nettype wire

[rtl/plip_in_stage.sv]
// ----------------------------------------------------------------------------
// plip_in_stage
// Input register: captures one character transaction per cycle while not stalled
// and holds it until the parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module plip_in_stage
    import plip_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    plip_in_if.sink    i_in,
    input  wire        i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // free when empty or when the held transaction moves on
    assign i_in.ready = !r_valid || i_advance;
    assign w_load     = i_in.valid && i_in.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.character     <= i_in.character;
            r_item.last_char     <= i_in.last_char;
            r_item.empty_literal <= i_in.empty_literal;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/plip_parse.sv]
// ----------------------------------------------------------------------------
// plip_parse
// Literal state, digit accumulate, result register. Folds one character per
// cycle into accumulator unless stalled; result on last char or empty literal.
// ----------------------------------------------------------------------------
`default_nettype none

module plip_parse
    import plip_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
)
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  t_item      i_item,
    output logic       o_advance,
    plip_out_if.source o_out
);

    localparam int unsigned EXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

    logic [1:0]            r_pos,   n_pos;
    logic                  r_fz,    n_fz;
    logic [1:0]            r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_acc,   n_acc;
    logic                  r_err,   n_err;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_out_error;

    logic                  w_fire;
    logic                  w_take;
    logic [1:0]            w_radix;
    t_digit                w_dig;
    logic                  w_dig_bad;
    logic [VALUE_BITS-1:0] w_dig_ext;
    logic [VALUE_BITS-1:0] w_acc_next;
    logic [EXT_W-1:0]      w_acc_ext;
    logic                  w_emit;

    // stage moves whenever the result register can take a result
    assign o_advance = !r_out_valid || o_out.ready;
    assign w_fire    = i_valid && o_advance;

    // prefix handling: pick radix for this character and whether it is a digit
    always_comb begin
        n_pos   = r_pos;
        n_fz    = r_fz;
        n_radix = r_radix;
        w_take  = 1'b1;
        w_radix = r_radix;
        if (r_pos == POS_FIRST) begin
            n_pos = POS_SECOND;
            if (i_item.character == CHAR_ZERO && !i_item.last_char) begin
                n_fz   = 1'b1;
                w_take = 1'b0;
            end else begin
                w_radix = RADIX_DEC;
                n_radix = RADIX_DEC;
            end
        end else if (r_pos == POS_SECOND && r_fz) begin
            n_pos = POS_LATER;
            if (i_item.character == CHAR_UPPER_X) begin
                n_radix = RADIX_HEX;
                w_take  = 1'b0;
            end else if (i_item.character == CHAR_UPPER_B) begin
                n_radix = RADIX_BIN;
                w_take  = 1'b0;
            end else begin
                n_radix = RADIX_OCT;
                w_radix = RADIX_OCT;
            end
        end else begin
            n_pos = POS_LATER;
        end
    end

    // digit decode and multiply by radix as shifts and adds
    assign w_dig     = char_digit(i_item.character);
    assign w_dig_bad = w_dig.bad || digit_out_of_range(w_radix, w_dig.val);
    assign w_dig_ext = VALUE_BITS'(w_dig.val);

    always_comb begin
        unique case (w_radix)
            RADIX_DEC: w_acc_next = (r_acc << 3) + (r_acc << 1) + w_dig_ext;
            RADIX_HEX: w_acc_next = (r_acc << 4) + w_dig_ext;
            RADIX_BIN: w_acc_next = (r_acc << 1) + w_dig_ext;
            RADIX_OCT: w_acc_next = (r_acc << 3) + w_dig_ext;
            default:   w_acc_next = r_acc;
        endcase
    end

    // accumulate, sticky error
    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (w_take) begin
            if (w_dig_bad) begin
                n_err = 1'b1;
            end else begin
                n_acc = w_acc_next;
            end
        end
    end

    assign w_emit    = i_item.empty_literal || i_item.last_char;
    assign w_acc_ext = EXT_W'(n_acc);

    // literal state, cleared after every result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FIRST;
            r_fz    <= 1'b0;
            r_radix <= RADIX_DEC;
            r_acc   <= '0;
            r_err   <= 1'b0;
        end else if (w_fire) begin
            if (w_emit) begin
                r_pos   <= POS_FIRST;
                r_fz    <= 1'b0;
                r_radix <= RADIX_DEC;
                r_acc   <= '0;
                r_err   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_fz    <= n_fz;
                r_radix <= n_radix;
                r_acc   <= n_acc;
                r_err   <= n_err;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= w_fire && w_emit;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            if (i_item.empty_literal || n_err) begin
                r_out_value <= '0;
            end else begin
                r_out_value <= w_acc_ext[VALUE_W-1:0];
            end
            r_out_error <= !i_item.empty_literal && n_err;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.error = r_out_error;

endmodule

`default_nettype wire

[rtl/prefixed_integer_literal_parser_core.sv]
// ----------------------------------------------------------------------------
// prefixed_integer_literal_parser_core
// Parses an integer literal arriving one character per transaction, with
// 0X / 0B / leading-zero octal prefixes, and returns value and error flag.
// ----------------------------------------------------------------------------
// path: an accepted last character (or empty literal) passes the input register
//   and then the result register before its result shows on the output channel
// throughput: 1 character per cycle unless a held result is not taken; the
//   accumulator update is one shift-and-add per character
// reset: synchronous active-low i_rst_n clears both valid flags and the
//   literal state (first position, decimal, zero accumulator, no error)
`default_nettype none

module prefixed_integer_literal_parser_core
    import plip_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
)
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    plip_in_if.sink    i_in,
    plip_out_if.source o_out
);

    logic  w_stg_valid;
    t_item w_stg_item;
    logic  w_advance;

    // input register
    plip_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_stg_valid),
        .o_item    (w_stg_item)
    );

    // parse and result register
    plip_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_stg_valid),
        .i_item    (w_stg_item),
        .o_advance (w_advance),
        .o_out     (o_out)
    );

    // an error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> (o_out.value == '0))
        else $error("error result with nonzero value");

    // an empty literal gives a clean zero result in the next cycle
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stg_valid && w_stg_item.empty_literal && w_advance) |=>
        (o_out.valid && (o_out.value == '0) && !o_out.error))
        else $error("empty literal did not produce zero result");

    // input only stalls behind a held result that is not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (w_stg_valid && o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
